// ----- hdl/swms_pkg.sv -----
package swms_pkg;

  localparam int unsigned CHANNELS    = 8;
  localparam int unsigned WINDOW_MAX  = 256;
  localparam int unsigned SAMPLE_BITS = 16;

  localparam int unsigned CH_W    = 3;
  localparam int unsigned WIN_W   = 9;
  localparam int unsigned SLOT_W  = $clog2(WINDOW_MAX);
  localparam int unsigned ADDR_W  = CH_W + SLOT_W;
  localparam int unsigned STORE_DEPTH = 1 << ADDR_W;

  localparam int unsigned SUM_W   = 24;
  localparam int unsigned SQ_W    = 39;
  localparam int unsigned PROD_W  = 2 * SAMPLE_BITS - 1;
  localparam int unsigned MEAN_W  = 24;
  localparam int unsigned STD_W   = 24;

  // divider: quotient / shift register width, divisor width, step counter
  localparam int unsigned NUM_W   = 47;
  localparam int unsigned DVS_W   = 17;
  localparam int unsigned DCNT_W  = 6;
  localparam int unsigned MEAN_STEPS = MEAN_W;
  localparam int unsigned VAR_STEPS  = NUM_W;

  // square root: working width and step counter
  localparam int unsigned RT_W    = 48;
  localparam int unsigned RCNT_W  = 5;
  localparam int unsigned RT_STEPS = 24;

  localparam logic [WIN_W-1:0] WIN_RESET = WIN_W'(16);

  typedef struct packed {
    logic [CH_W-1:0]               channel;
    logic signed [SAMPLE_BITS-1:0] sample;
  } in_item_t;

  typedef struct packed {
    logic [CH_W-1:0]          out_channel;
    logic signed [MEAN_W-1:0] window_mean;
    logic [STD_W-1:0]         window_std_dev;
  } out_item_t;

  // Clamp a written window length into 1..WINDOW_MAX.
  function automatic logic [WIN_W-1:0] eff_window(input logic [WIN_W-1:0] v);
    logic [WIN_W-1:0] r;
    if (v == '0) begin
      r = WIN_W'(1);
    end else if (v > WIN_W'(WINDOW_MAX)) begin
      r = WIN_W'(WINDOW_MAX);
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

// ----- hdl/swms_ram.sv -----
module swms_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hdl/swms_front.sv -----
module swms_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  swms_pkg::in_item_t in_data_i,
  output logic               q_valid_o,
  output swms_pkg::in_item_t q_item_o,
  input  logic               q_pop_i
);
  import swms_pkg::*;

  in_item_t    buf_q [2];
  logic        wr_ptr_q, wr_ptr_d;
  logic        rd_ptr_q, rd_ptr_d;
  logic [1:0]  cnt_q, cnt_d;
  logic        push;
  logic        pop;
  logic        ch_ok;

  assign in_ready_o = (cnt_q != 2'd2);
  // drop samples for channels that do not exist
  assign ch_ok = (32'(in_data_i.channel) < CHANNELS);
  assign push  = in_valid_i && in_ready_o && ch_ok;
  assign pop   = q_pop_i && (cnt_q != 2'd0);

  assign q_valid_o = (cnt_q != 2'd0);
  assign q_item_o  = buf_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      buf_q[wr_ptr_q] <= in_data_i;
    end
  end

endmodule

// ----- hdl/swms_div.sv -----
module swms_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [swms_pkg::DVS_W-1:0] rem0_i,
  input  logic [swms_pkg::NUM_W-1:0] bits_i,
  input  logic [swms_pkg::DVS_W-1:0] divisor_i,
  input  logic [swms_pkg::DCNT_W-1:0] steps_i,
  output logic                       done_o,
  output logic [swms_pkg::NUM_W-1:0] quot_o
);
  import swms_pkg::*;

  logic [DVS_W-1:0]  rem_q, rem_d;
  logic [NUM_W-1:0]  sh_q, sh_d;
  logic [DVS_W-1:0]  dvs_q;
  logic [DCNT_W-1:0] cnt_q, cnt_d;
  logic              done_q, done_d;
  logic [DVS_W:0]    trial;
  logic [DVS_W:0]    diff;
  logic              fits;

  // one quotient bit per cycle, restoring
  assign trial = {rem_q, sh_q[NUM_W-1]};
  assign diff  = trial - {1'b0, dvs_q};
  assign fits  = (trial >= {1'b0, dvs_q});

  always_comb begin
    rem_d  = rem_q;
    sh_d   = sh_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d = rem0_i;
      sh_d  = bits_i;
      cnt_d = steps_i;
    end else if (cnt_q != '0) begin
      rem_d  = fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
      sh_d   = {sh_q[NUM_W-2:0], fits};
      cnt_d  = cnt_q - DCNT_W'(1);
      done_d = (cnt_q == DCNT_W'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    sh_q  <= sh_d;
    if (start_i) begin
      dvs_q <= divisor_i;
    end
  end

  assign done_o = done_q;
  assign quot_o = sh_q;

endmodule

// ----- hdl/swms_sqrt.sv -----
module swms_sqrt (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [swms_pkg::NUM_W-1:0] radicand_i,
  output logic                       done_o,
  output logic [swms_pkg::STD_W-1:0] root_o
);
  import swms_pkg::*;

  logic [RT_W-1:0]   n_q, n_d;
  logic [RT_W-1:0]   root_q, root_d;
  logic [RT_W-1:0]   bit_q, bit_d;
  logic [RCNT_W-1:0] cnt_q, cnt_d;
  logic              done_q, done_d;
  logic [RT_W-1:0]   trial;

  assign trial = root_q + bit_q;

  // two radicand bits per cycle
  always_comb begin
    n_d    = n_q;
    root_d = root_q;
    bit_d  = bit_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (start_i) begin
      n_d    = RT_W'(radicand_i);
      root_d = '0;
      bit_d  = RT_W'(1) << (2 * RT_STEPS - 2);
      cnt_d  = RCNT_W'(RT_STEPS);
    end else if (cnt_q != '0) begin
      if (n_q >= trial) begin
        n_d    = n_q - trial;
        root_d = (root_q >> 1) + bit_q;
      end else begin
        root_d = root_q >> 1;
      end
      bit_d  = bit_q >> 2;
      cnt_d  = cnt_q - RCNT_W'(1);
      done_d = (cnt_q == RCNT_W'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q    <= n_d;
    root_q <= root_d;
    bit_q  <= bit_d;
  end

  assign done_o = done_q;
  assign root_o = root_q[STD_W-1:0];

endmodule

// ----- hdl/swms_back.sv -----
module swms_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [swms_pkg::WIN_W-1:0] cfg_wdata_i,
  input  logic                       q_valid_i,
  input  swms_pkg::in_item_t         q_item_i,
  output logic                       q_pop_o,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output swms_pkg::out_item_t        out_data_o
);
  import swms_pkg::*;

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_READ = 4'd1;
  localparam logic [3:0] ST_ACC  = 4'd2;
  localparam logic [3:0] ST_MUL0 = 4'd3;
  localparam logic [3:0] ST_MUL1 = 4'd4;
  localparam logic [3:0] ST_SUMW = 4'd5;
  localparam logic [3:0] ST_DIFF = 4'd6;
  localparam logic [3:0] ST_DIVM = 4'd7;
  localparam logic [3:0] ST_DIVV = 4'd8;
  localparam logic [3:0] ST_SQRT = 4'd9;
  localparam logic [3:0] ST_OUT  = 4'd10;

  localparam int unsigned PLO_W = WIN_W + 20;
  localparam int unsigned PHI_W = WIN_W + SQ_W - 20;
  localparam int unsigned WS_W  = 2 * SUM_W;

  logic [3:0]        state_q, state_d;
  logic [WIN_W-1:0]  win_q;

  logic [WIN_W-1:0]        fill_q  [CHANNELS];
  logic [SLOT_W-1:0]       wslot_q [CHANNELS];
  logic signed [SUM_W-1:0] sum_q   [CHANNELS];
  logic [SQ_W-1:0]         sumsq_q [CHANNELS];

  logic [CH_W-1:0]               ch_q;
  logic signed [SAMPLE_BITS-1:0] x_q;
  logic [SLOT_W-1:0]             cur_slot_q;
  logic [WIN_W-1:0]              cur_fill_q;
  logic                          full_q;
  logic signed [SAMPLE_BITS-1:0] old_q;
  logic [PROD_W-1:0]             sq_new_q, sq_old_q;
  logic signed [SUM_W-1:0]       work_sum_q;
  logic [SQ_W-1:0]               work_sq_q;
  logic [SUM_W-1:0]              abs_q;
  logic [PLO_W-1:0]              plo_q;
  logic [PHI_W-1:0]              phi_q;
  logic [WS_W-1:0]               sqsum_q, wsum_q;
  logic [DVS_W-1:0]              wsq_q;
  logic [NUM_W-1:0]              num_q;
  logic signed [MEAN_W-1:0]      mean_q;
  logic                          out_valid_q, out_valid_d;
  out_item_t                     out_data_q;

  logic [SAMPLE_BITS-1:0]        ram_rdata;
  logic signed [SAMPLE_BITS-1:0] old_sel;
  logic signed [2*SAMPLE_BITS-1:0] p_new, p_old;
  logic signed [SUM_W-1:0]       sum_next;
  logic [SQ_W-1:0]               sumsq_next;
  logic [WIN_W-1:0]              slot_inc, fill_inc, fill_next;
  logic [SLOT_W-1:0]             slot_next;
  logic                          now_full;
  logic                          out_load;

  logic              div_start, div_done;
  logic [DVS_W-1:0]  div_rem0, div_dvs;
  logic [NUM_W-1:0]  div_bits, div_quot;
  logic [DCNT_W-1:0] div_steps;
  logic              rt_start, rt_done;
  logic [STD_W-1:0]  rt_root;
  logic [MEAN_W-1:0] mean_mag;

  swms_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (state_q == ST_READ),
    .waddr_i ({ch_q, cur_slot_q}),
    .wdata_i (x_q),
    .re_i    ((state_q == ST_IDLE) && q_valid_i),
    .raddr_i ({q_item_i.channel, wslot_q[q_item_i.channel]}),
    .rdata_o (ram_rdata)
  );

  assign q_pop_o = (state_q == ST_IDLE);

  // sample update arithmetic
  assign old_sel = full_q ? $signed(ram_rdata) : '0;
  assign p_new   = x_q * x_q;
  assign p_old   = old_sel * old_sel;

  assign sum_next = sum_q[ch_q]
                  - {{(SUM_W-SAMPLE_BITS){old_q[SAMPLE_BITS-1]}}, old_q}
                  + {{(SUM_W-SAMPLE_BITS){x_q[SAMPLE_BITS-1]}}, x_q};
  assign sumsq_next = sumsq_q[ch_q] - SQ_W'(sq_old_q) + SQ_W'(sq_new_q);

  assign slot_inc  = {1'b0, cur_slot_q} + WIN_W'(1);
  assign slot_next = (slot_inc == win_q) ? '0 : slot_inc[SLOT_W-1:0];
  assign fill_inc  = cur_fill_q + WIN_W'(1);
  assign now_full  = full_q || (fill_inc == win_q);
  assign fill_next = full_q ? cur_fill_q : fill_inc;

  // shared divider: mean first, then the scaled variance
  always_comb begin
    div_start = 1'b0;
    div_rem0  = DVS_W'(abs_q[SUM_W-1:16]);
    div_bits  = {abs_q[15:0], 31'b0};
    div_dvs   = DVS_W'(win_q);
    div_steps = DCNT_W'(MEAN_STEPS);
    if (state_q == ST_SUMW) begin
      div_start = 1'b1;
    end else if ((state_q == ST_DIVM) && div_done) begin
      div_start = 1'b1;
      div_rem0  = DVS_W'(num_q[NUM_W-1:31]);
      div_bits  = {num_q[30:0], 16'b0};
      div_dvs   = wsq_q;
      div_steps = DCNT_W'(VAR_STEPS);
    end
  end

  assign rt_start = (state_q == ST_DIVV) && div_done;
  assign mean_mag = div_quot[MEAN_W-1:0];

  swms_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .rem0_i    (div_rem0),
    .bits_i    (div_bits),
    .divisor_i (div_dvs),
    .steps_i   (div_steps),
    .done_o    (div_done),
    .quot_o    (div_quot)
  );

  swms_sqrt u_sqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (rt_start),
    .radicand_i (div_quot),
    .done_o     (rt_done),
    .root_o     (rt_root)
  );

  assign out_load = (state_q == ST_OUT) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (q_valid_i) state_d = ST_READ;
      ST_READ: state_d = ST_ACC;
      ST_ACC:  state_d = now_full ? ST_MUL0 : ST_IDLE;
      ST_MUL0: state_d = ST_MUL1;
      ST_MUL1: state_d = ST_SUMW;
      ST_SUMW: state_d = ST_DIFF;
      ST_DIFF: state_d = ST_DIVM;
      ST_DIVM: if (div_done) state_d = ST_DIVV;
      ST_DIVV: if (div_done) state_d = ST_SQRT;
      ST_SQRT: if (rt_done) state_d = ST_OUT;
      ST_OUT:  if (out_load) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      win_q       <= WIN_RESET;
      out_valid_q <= 1'b0;
      for (int i = 0; i < CHANNELS; i++) begin
        fill_q[i]  <= '0;
        wslot_q[i] <= '0;
        sum_q[i]   <= '0;
        sumsq_q[i] <= '0;
      end
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        win_q <= eff_window(cfg_wdata_i);
        for (int i = 0; i < CHANNELS; i++) begin
          fill_q[i]  <= '0;
          wslot_q[i] <= '0;
          sum_q[i]   <= '0;
          sumsq_q[i] <= '0;
        end
      end else if (state_q == ST_ACC) begin
        fill_q[ch_q]  <= fill_next;
        wslot_q[ch_q] <= slot_next;
        sum_q[ch_q]   <= sum_next;
        sumsq_q[ch_q] <= sumsq_next;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE) begin
      ch_q       <= q_item_i.channel;
      x_q        <= q_item_i.sample;
      cur_slot_q <= wslot_q[q_item_i.channel];
      cur_fill_q <= fill_q[q_item_i.channel];
      full_q     <= (fill_q[q_item_i.channel] >= win_q);
    end
    if (state_q == ST_READ) begin
      old_q    <= old_sel;
      sq_new_q <= p_new[PROD_W-1:0];
      sq_old_q <= p_old[PROD_W-1:0];
    end
    if (state_q == ST_ACC) begin
      work_sum_q <= sum_next;
      work_sq_q  <= sumsq_next;
    end
    if (state_q == ST_MUL0) begin
      abs_q <= work_sum_q[SUM_W-1] ? SUM_W'(-work_sum_q) : SUM_W'(work_sum_q);
      plo_q <= PLO_W'(win_q) * PLO_W'(work_sq_q[19:0]);
    end
    if (state_q == ST_MUL1) begin
      phi_q   <= PHI_W'(win_q) * PHI_W'(work_sq_q[SQ_W-1:20]);
      sqsum_q <= WS_W'(abs_q) * WS_W'(abs_q);
    end
    if (state_q == ST_SUMW) begin
      wsum_q <= {phi_q[WS_W-21:0], 20'b0} + WS_W'(plo_q);
      wsq_q  <= DVS_W'(win_q) * DVS_W'(win_q);
    end
    if (state_q == ST_DIFF) begin
      num_q <= (wsum_q >= sqsum_q) ? NUM_W'(wsum_q - sqsum_q) : '0;
    end
    if ((state_q == ST_DIVM) && div_done) begin
      mean_q <= work_sum_q[SUM_W-1] ? -$signed(mean_mag) : $signed(mean_mag);
    end
    if (out_load) begin
      out_data_q.out_channel    <= ch_q;
      out_data_q.window_mean    <= mean_q;
      out_data_q.window_std_dev <= rt_root;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// ----- hdl/sliding_window_mean_stddev.sv -----
// Rolling mean and population standard deviation over the most recent
// samples of each of eight channels, the window length set by configuration.
// Input channel: in_valid_i / in_ready_o with in_data_i (channel, sample).
// A transfer whose channel window is not yet full updates the state and
// produces nothing; once full, every transfer produces one result on
// out_valid_o / out_ready_i with out_data_o (channel, mean, std deviation),
// both with 8 fractional bits.
// Configuration: cfg_we_i writes cfg_wdata_i as the window length (0 acts as
// 1, lengths above the maximum clamp) and empties every channel window.
// Write only while the block is idle.
// Processing: a sample that produces no result passes through the store read
// and the window update and then frees the back end. A result waits for the
// store read and update, the mean in 24 steps and the variance in 47 steps of
// one shared restoring divider, and the square root in 24 steps; the back end
// takes no new sample until the result enters the output register.
// A two-entry queue sits in front, so up to two samples are taken while the
// back end works or while a result waits in the output register.
// Reset clears windows and sums and sets the window length to 16; the
// sample store needs no clearing since only written entries are read.
// A stalled receiver holds the result and, once the queue fills, the input.
module sliding_window_mean_stddev (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  swms_pkg::in_item_t         in_data_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output swms_pkg::out_item_t        out_data_o,
  input  logic                       cfg_we_i,
  input  logic [swms_pkg::WIN_W-1:0] cfg_wdata_i
);
  import swms_pkg::*;

  logic     q_valid;
  in_item_t q_item;
  logic     q_pop;

  // accept and filter samples, buffer them for the back end
  swms_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .q_valid_o  (q_valid),
    .q_item_o   (q_item),
    .q_pop_i    (q_pop)
  );

  // window update, statistics and output register
  swms_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .q_valid_i   (q_valid),
    .q_item_i    (q_item),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ----- hdl/swms_checker.sv -----
module swms_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_ready_o,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input swms_pkg::out_item_t out_data_o
);
  import swms_pkg::*;

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  a_reset_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !out_valid_o)
    else $error("result valid right after reset");

  a_reset_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> in_ready_o)
    else $error("input not ready after reset");

  a_std_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.window_std_dev <= STD_W'(8388608))
    else $error("deviation out of range");

endmodule

bind sliding_window_mean_stddev swms_checker u_swms_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

// ----- test/tb_sliding_window_mean_stddev.sv -----
module tb_sliding_window_mean_stddev;
  import swms_pkg::*;

  // Cycles in a row with no transfer on either side before the run is ended.
  localparam int unsigned HANG_LIMIT = 20000;
  // A sample that produces no result can keep the back end busy after the
  // last result; let this many cycles pass before touching the window length.
  localparam int unsigned SETTLE_CYCLES = 200;

  typedef enum int {
    IDLE_NONE,
    IDLE_SEND,
    IDLE_RECV,
    IDLE_BOTH
  } idle_mode_e;

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_ready_o;
  in_item_t            in_data_i;
  logic                out_valid_o;
  logic                out_ready_i;
  out_item_t           out_data_o;
  logic                cfg_we_i;
  logic [WIN_W-1:0]    cfg_wdata_i;

  sliding_window_mean_stddev dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  // Shadow of the block state: window length, per-channel history and sums.
  int unsigned     win_len;
  logic signed [SAMPLE_BITS-1:0] history [CHANNELS][WINDOW_MAX];
  longint          ch_sum   [CHANNELS];
  longint unsigned ch_sum_sq[CHANNELS];
  int unsigned     ch_fill  [CHANNELS];
  int unsigned     ch_slot  [CHANNELS];

  out_item_t  stats_pending[$];
  idle_mode_e idle_mode;
  bit         recv_hold;       // long receiver hold-off in progress
  int unsigned errors;
  int unsigned quiet_cycles;

  // Directed stimulus; a row with has_result set carries a typed-in answer.
  typedef struct {
    logic [CH_W-1:0]        channel;
    logic [SAMPLE_BITS-1:0] sample;
    bit                     has_result;
    logic [MEAN_W-1:0]      mean;
    logic [STD_W-1:0]       std_dev;
  } directed_row_t;

  function automatic longint unsigned isqrt(longint unsigned n);
    longint unsigned root;
    longint unsigned bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= root + bitv) begin
        n -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  // Empty every channel window, as a window-length write does.
  function automatic void clear_windows();
    for (int c = 0; c < CHANNELS; c++) begin
      ch_sum[c] = 0;
      ch_sum_sq[c] = 0;
      ch_fill[c] = 0;
      ch_slot[c] = 0;
    end
  endfunction

  // Advance the shadow state by one sample; return 1 with the statistics
  // once the channel window is full.
  function automatic bit window_stats(input in_item_t item, output out_item_t res);
    longint          x;
    longint          old;
    longint          mean;
    longint unsigned sum_abs;
    longint unsigned num;
    int unsigned     slot;
    int unsigned     ch;
    res = '0;
    ch = 32'(item.channel);
    x = 64'(item.sample);
    slot = ch_slot[ch] % win_len;
    if (ch_fill[ch] >= win_len) begin
      old = history[ch][slot];
      ch_sum[ch] -= old;
      ch_sum_sq[ch] -= longint'(old * old);
    end
    history[ch][slot] = item.sample;
    ch_sum[ch] += x;
    ch_sum_sq[ch] += longint'(x * x);
    ch_slot[ch] = (slot + 1) % win_len;
    if (ch_fill[ch] < win_len) ch_fill[ch]++;
    if (ch_fill[ch] < win_len) return 1'b0;
    mean = (ch_sum[ch] * 256) / longint'(win_len);
    sum_abs = (ch_sum[ch] < 0) ? longint'(-ch_sum[ch]) : ch_sum[ch];
    if (longint'(win_len) * ch_sum_sq[ch] < sum_abs * sum_abs) num = 0;
    else num = longint'(win_len) * ch_sum_sq[ch] - sum_abs * sum_abs;
    res.out_channel    = item.channel;
    res.window_mean    = mean[MEAN_W-1:0];
    res.window_std_dev = STD_W'(isqrt((num * 65536) / (longint'(win_len) * win_len)));
    return 1'b1;
  endfunction

  // Offer one sample, hold it until the transfer, and record the prediction.
  // Valid stays up after the transfer until the next sample or a drain.
  task automatic send_sample(input in_item_t item, input bit typed, input out_item_t typed_res);
    out_item_t   res;
    bit          has;
    int unsigned idle_pct;
    idle_pct = (idle_mode == IDLE_BOTH) ? 25 : 51;
    if (idle_mode inside {IDLE_SEND, IDLE_BOTH}) begin
      while ($urandom_range(99) < idle_pct) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    has = window_stats(item, res);
    if (typed) begin
      if (!has || res != typed_res) begin
        $display("%0t: typed-in row disagrees, expected %h actual prediction %h",
                 $time, typed_res, res);
        errors++;
      end
    end
    if (has) stats_pending.push_back(res);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (stats_pending.size() != 0) @(posedge clk_i);
  endtask

  // Change the window length only with nothing in flight.
  task automatic write_window(input logic [WIN_W-1:0] len);
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= len;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    win_len = (len == 0) ? 1 : ((len > WINDOW_MAX) ? WINDOW_MAX : len);
    clear_windows();
  endtask

  // Random sample: a quarter at the extremes, a quarter near zero, the rest over the full range.
  function automatic in_item_t rand_item(input int unsigned ch_hi);
    in_item_t it;
    it.channel = CH_W'($urandom_range(ch_hi));
    case ($urandom_range(3))
      0:       it.sample = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
      1:       it.sample = SAMPLE_BITS'($urandom_range(200) - 100);
      default: it.sample = SAMPLE_BITS'($urandom);
    endcase
    return it;
  endfunction

  task automatic random_burst(input int unsigned count, input int unsigned ch_hi);
    for (int i = 0; i < count; i++) send_sample(rand_item(ch_hi), 1'b0, '0);
  endtask

  // Receiver: accept results, stall at random in the stalling modes.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (stats_pending.size() == 0) begin
          $display("%0t: unexpected result, expected none actual %h", $time, out_data_o);
          errors++;
        end else begin
          if (out_data_o.out_channel != stats_pending[0].out_channel) begin
            $display("%0t: out_channel expected %0d actual %0d", $time,
                     stats_pending[0].out_channel, out_data_o.out_channel);
            errors++;
          end
          if (out_data_o.window_mean != stats_pending[0].window_mean) begin
            $display("%0t: window_mean expected %0d actual %0d", $time,
                     stats_pending[0].window_mean, out_data_o.window_mean);
            errors++;
          end
          if (out_data_o.window_std_dev != stats_pending[0].window_std_dev) begin
            $display("%0t: window_std_dev expected %0d actual %0d", $time,
                     stats_pending[0].window_std_dev, out_data_o.window_std_dev);
            errors++;
          end
          void'(stats_pending.pop_front());
        end
      end
      if (recv_hold) out_ready_i <= 1'b0;
      else if (idle_mode == IDLE_BOTH) out_ready_i <= ($urandom_range(99) >= 25);
      else if (idle_mode == IDLE_RECV) out_ready_i <= ($urandom_range(99) >= 51);
      else out_ready_i <= 1'b1;
    end
  end

  // Watchdog: end the run when no transfer happens for too long.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= HANG_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  directed_row_t directed [$];

  initial begin
    out_item_t typed_res;
    in_item_t  item;
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    in_data_i    = '0;
    out_ready_i  = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_wdata_i  = '0;
    idle_mode    = IDLE_NONE;
    recv_hold    = 1'b0;
    errors       = 0;
    win_len      = 16;
    clear_windows();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Window of one: each sample is its own mean with zero deviation.
    directed.push_back('{3'd0, 16'h7FFF, 1'b1, 24'h7FFF00, 24'd0});
    directed.push_back('{3'd7, 16'h8000, 1'b1, 24'h800000, 24'd0});
    directed.push_back('{3'd3, 16'h0000, 1'b1, 24'h000000, 24'd0});
    directed.push_back('{3'd5, 16'hFFFF, 1'b1, 24'hFFFF00, 24'd0});
    directed.push_back('{3'd2, 16'h5555, 1'b1, 24'h555500, 24'd0});
    directed.push_back('{3'd6, 16'hAAAA, 1'b1, 24'hAAAA00, 24'd0});
    write_window(9'd0);  // zero acts as one
    foreach (directed[i]) begin
      typed_res = '{directed[i].channel, directed[i].mean, directed[i].std_dev};
      item = '{directed[i].channel, directed[i].sample};
      send_sample(item, directed[i].has_result, typed_res);
    end
    // Window of two, extremes alternating: mean -128, deviation 32767.5.
    write_window(9'd2);
    item = '{3'd1, 16'sh7FFF};
    send_sample(item, 1'b0, '0);
    item = '{3'd1, 16'sh8000};
    send_sample(item, 1'b1, '{3'd1, -24'sd128, 24'd8388480});
    // Rollover with extremes, then a still-filling window on another channel.
    for (int i = 0; i < 6; i++) begin
      item = '{3'd1, (i % 2) ? 16'sh8000 : 16'sh7FFF};
      send_sample(item, 1'b0, '0);
    end
    item = '{3'd4, -16'sd3};
    send_sample(item, 1'b0, '0);

    // Random phases over several window lengths and idling modes.
    write_window(9'd16);
    idle_mode = IDLE_NONE;
    random_burst(300, 7);
    write_window(9'd3);
    idle_mode = IDLE_SEND;
    random_burst(300, 7);
    write_window(9'd511);  // clamps to the maximum
    idle_mode = IDLE_NONE;
    random_burst(300, 1);
    write_window(9'd256);
    idle_mode = IDLE_RECV;
    random_burst(300, 0);
    write_window(9'd7);
    idle_mode = IDLE_BOTH;
    random_burst(250, 7);

    // Hold the receiver off while samples keep coming to fill the queue.
    idle_mode = IDLE_NONE;
    write_window(9'd1);
    fork
      begin
        recv_hold = 1'b1;
        repeat (600) @(posedge clk_i);
        recv_hold = 1'b0;
      end
      random_burst(40, 7);
    join
    drain();  // sender waits for every result
    random_burst(200, 7);

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hdl/swms_pkg.sv
hdl/swms_ram.sv
hdl/swms_front.sv
hdl/swms_div.sv
hdl/swms_sqrt.sv
hdl/swms_back.sv
hdl/sliding_window_mean_stddev.sv
hdl/swms_checker.sv
test/tb_sliding_window_mean_stddev.sv
